/* src/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Transfer types, status codes and the byte-wide CRC-16 update shared by the
// modules of the response checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

   // Kind of item on the request channel.
   localparam logic ITEM_BYTE = 1'b0;
   localparam logic ITEM_IDLE = 1'b1;

   // Frame verdicts reported in the status field.
   localparam logic [2:0] STATUS_KEPT       = 3'd0;
   localparam logic [2:0] STATUS_NO_REQUEST = 3'd1;
   localparam logic [2:0] STATUS_EXCEPTION  = 3'd2;
   localparam logic [2:0] STATUS_CRC_ERROR  = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW   = 3'd4;
   localparam logic [2:0] STATUS_OK         = 3'd5;

   localparam logic [15:0] CRC_START = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [7:0]  EXC_BIT   = 8'h80;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
      logic       request_pending;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  frame_address;
      logic [6:0]  function_code;
      logic        is_exception;
      logic [7:0]  exception_code;
      logic [8:0]  frame_length;
      logic [31:0] good_frame_count;
      logic [31:0] crc_error_count;
      logic        transaction_done;
   } rsp_item_type;

   // One byte of the reflected CRC-16, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* src/mbrc_in_stage.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker input stage
// Registers one request transfer and holds it until the frame logic takes it.
// ----------------------------------------------------------------------------
module mbrc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mbrc_pkg::req_item_type req_data,
   input  logic                  advance,
   output logic                  item_valid,
   output mbrc_pkg::req_item_type item_data
);

   logic                   valid_ff;
   logic                   valid_in;
   mbrc_pkg::req_item_type data_ff;
   logic                   accept;

   // The stage is free when empty or when its item moves on this cycle.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

/* src/mbrc_frame_core.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker frame core
// Keeps the running CRC, byte count, header bytes and frame counters, and
// works out the verdict for a frame on a line-idle item.
// ----------------------------------------------------------------------------
module mbrc_frame_core #(
   parameter int MAX_FRAME_BYTES = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  mbrc_pkg::req_item_type item_data,
   output mbrc_pkg::rsp_item_type result
);

   localparam int CW = $clog2(MAX_FRAME_BYTES + 2);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_FRAME_BYTES + 1);
   localparam logic [CW-1:0] COUNT_MAX   = CW'(MAX_FRAME_BYTES);
   localparam logic [CW-1:0] MIN_FRAME   = CW'(4);
   localparam logic [CW-1:0] MIN_EXC     = CW'(5);

   logic [15:0]   crc_ff,    crc_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [7:0]    first_ff,  first_in;
   logic [7:0]    second_ff, second_in;
   logic [7:0]    third_ff,  third_in;
   logic [31:0]   good_ff,   good_in;
   logic [31:0]   errors_ff, errors_in;

   logic [2:0]    status;
   logic          is_exc;
   logic          crc_ok;
   logic [CW+8:0] count_ext;

   assign is_exc    = (second_ff & mbrc_pkg::EXC_BIT) != 8'h00;
   assign crc_ok    = crc_ff == 16'h0000;
   assign count_ext = {9'b0, count_ff};

   always_comb begin
      if (count_ff < MIN_FRAME) begin
         status = mbrc_pkg::STATUS_KEPT;
      end else if (!item_data.request_pending) begin
         status = mbrc_pkg::STATUS_NO_REQUEST;
      end else if (is_exc) begin
         if (count_ff < MIN_EXC) begin
            status = mbrc_pkg::STATUS_KEPT;
         end else if (!crc_ok) begin
            status = mbrc_pkg::STATUS_CRC_ERROR;
         end else begin
            status = mbrc_pkg::STATUS_EXCEPTION;
         end
      end else if (count_ff > COUNT_MAX) begin
         status = mbrc_pkg::STATUS_OVERFLOW;
      end else if (!crc_ok) begin
         status = mbrc_pkg::STATUS_CRC_ERROR;
      end else begin
         status = mbrc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      crc_in    = crc_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      second_in = second_ff;
      third_in  = third_ff;
      good_in   = good_ff;
      errors_in = errors_ff;
      if (item_data.req_type == mbrc_pkg::ITEM_BYTE) begin
         crc_in = mbrc_pkg::crc_byte(crc_ff, item_data.rx_byte);
         if (count_ff == CW'(0)) begin
            first_in = item_data.rx_byte;
         end else if (count_ff == CW'(1)) begin
            second_in = item_data.rx_byte;
         end else if (count_ff == CW'(2)) begin
            third_in = item_data.rx_byte;
         end
         if (count_ff < COUNT_LIMIT) begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (status == mbrc_pkg::STATUS_OK || status == mbrc_pkg::STATUS_EXCEPTION) begin
            good_in = good_ff + 32'd1;
         end
         if (status == mbrc_pkg::STATUS_CRC_ERROR) begin
            errors_in = errors_ff + 32'd1;
         end
         if (status != mbrc_pkg::STATUS_KEPT) begin
            crc_in    = mbrc_pkg::CRC_START;
            count_in  = '0;
            first_in  = 8'h00;
            second_in = 8'h00;
            third_in  = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= mbrc_pkg::CRC_START;
         count_ff  <= '0;
         first_ff  <= 8'h00;
         second_ff <= 8'h00;
         third_ff  <= 8'h00;
         good_ff   <= 32'd0;
         errors_ff <= 32'd0;
      end else if (advance) begin
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         third_ff  <= third_in;
         good_ff   <= good_in;
         errors_ff <= errors_in;
      end
   end

   always_comb begin
      result.status           = status;
      result.frame_address    = first_ff;
      result.function_code    = second_ff[6:0];
      result.is_exception     = is_exc;
      result.exception_code   = (status == mbrc_pkg::STATUS_EXCEPTION) ? third_ff : 8'h00;
      result.frame_length     = count_ext[8:0];
      result.good_frame_count = good_in;
      result.crc_error_count  = errors_in;
      result.transaction_done = (status == mbrc_pkg::STATUS_OK) ||
                                (status == mbrc_pkg::STATUS_EXCEPTION);
   end

endmodule

/* src/modbus_rtu_response_checker.sv */
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Checks received Modbus RTU response frames and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Usage: each transfer on the req_ channel is either one received byte
// (req_type clear) or a line-idle event (req_type set) that closes the frame.
// Bytes update the running CRC-16, the byte count and the stored header bytes
// and produce no response. Each line-idle event produces exactly one transfer
// on the rsp_ channel, carrying the verdict, header fields, frame length and
// both frame counters as they stand after the event.
// Flow: a request transfer is registered in the input stage; the frame logic
// processes it from that register, and the response to a line-idle transfer
// is registered in the result register. Throughput, set by the combinational
// CRC byte update in the frame core, is one request transfer per cycle while
// no line-idle item waits for the result register.
// Reset clears the frame state (CRC to its start value, count and header bytes
// to zero), both counters and both valid flags.
// While the receiver stalls, the waiting response holds; further byte
// transfers are still taken, and a second line-idle event waits in the input
// stage, which then stalls the sender until the response register frees up.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker #(
   parameter int MAX_FRAME_BYTES = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mbrc_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mbrc_pkg::rsp_item_type rsp_data
);

   logic                   item_valid;
   mbrc_pkg::req_item_type item_data;
   mbrc_pkg::rsp_item_type result;
   logic                   out_free;
   logic                   advance;
   logic                   result_fire;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   mbrc_pkg::rsp_item_type rsp_data_ff;

   // The result register is free when empty or when its transfer completes now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Bytes never wait for the result register; a line-idle item needs it free.
   assign advance = item_valid &&
                    (item_data.req_type == mbrc_pkg::ITEM_BYTE || out_free);
   assign result_fire = advance && item_data.req_type == mbrc_pkg::ITEM_IDLE;

   mbrc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   mbrc_frame_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item_data (item_data),
      .result    (result)
   );

   // Hold a stalled response; drop it once taken unless a new one replaces it.
   assign rsp_valid_in = result_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (result_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
